/* rtl/scalar_kalman_forward_filter_defines.svh */
// ----------------------------------------------------------------------------
// Scalar Kalman forward filter - assertion macros
// Shared assertion macros. Define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FORWARD_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FORWARD_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset.
`define SKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SKF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SKF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/skf_pkg.sv */
// ----------------------------------------------------------------------------
// Scalar Kalman forward filter - package
// Shared constants, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package skf_pkg;

    // Width of the unsigned Q0.16 decay factor.
    localparam int COEF_BITS      = 16;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CFG_IDX_W      = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_AR_COEF     = 3'd0;
    localparam cfg_idx_t REG_PROCESS_VAR = 3'd1;
    localparam cfg_idx_t REG_OBS_VAR     = 3'd2;
    localparam cfg_idx_t REG_BASELINE    = 3'd3;
    localparam cfg_idx_t REG_INITIAL_VAR = 3'd4;

    localparam logic [63:0] AR_COEF_RST  = 64'd52429;
    localparam logic [63:0] VAR_ONE_RST  = 64'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_GG,
        ST_MUL_V,
        ST_SUM_R,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL_FM,
        ST_SUM_FM,
        ST_SUM_FV
    } skf_state_t;

endpackage

/* rtl/skf_if.sv */
// ----------------------------------------------------------------------------
// Scalar Kalman forward filter - channel interfaces
// Valid/ready channels for the observation items and the result items.
// ----------------------------------------------------------------------------
interface skf_in_if import skf_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sample;
    logic signed [DATA_WIDTH-1:0] jump;
    logic                         restart;

    modport source (output valid, output sample, output jump, output restart, input ready);
    modport sink   (input valid, input sample, input jump, input restart, output ready);
endinterface

interface skf_out_if import skf_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] predicted_mean;
    logic        [DATA_WIDTH-2:0] predicted_var;
    logic signed [DATA_WIDTH-1:0] filtered_mean;
    logic        [DATA_WIDTH-2:0] filtered_var;

    modport source (output valid, output predicted_mean, output predicted_var,
                    output filtered_mean, output filtered_var, input ready);
    modport sink   (input valid, input predicted_mean, input predicted_var,
                    input filtered_mean, input filtered_var, output ready);
endinterface

/* rtl/skf_div.sv */
// ----------------------------------------------------------------------------
// Scalar Kalman forward filter - gain divider
// Restoring divider forming floor(num * 2^FRAC_BITS / den), one bit a cycle.
// ----------------------------------------------------------------------------
`include "scalar_kalman_forward_filter_defines.svh"

module skf_div import skf_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-2:0] num,
    input  logic [DATA_WIDTH-1:0] den,
    output logic                  done,
    output logic [FRAC_BITS:0]    quotient
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  zero_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DATA_WIDTH:0]   rem_reg;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [FRAC_BITS:0]    quo_reg;

    logic                  ge;
    logic [DATA_WIDTH:0]   diff;

    // The caller guarantees num <= den, so each remainder after subtraction stays below den.
    assign ge   = rem_reg >= {1'b0, den_reg};
    assign diff = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rem_reg  <= {2'b00, num};
            den_reg  <= den;
            zero_reg <= (den == '0);
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= {diff[DATA_WIDTH-1:0], 1'b0};
            quo_reg <= {quo_reg[FRAC_BITS-1:0], ge};
        end
    end

    assign done     = done_reg;
    // A zero denominator gives a zero gain.
    assign quotient = zero_reg ? '0 : quo_reg;

    `SKF_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy_reg, busy_reg)
    `SKF_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg)
    `SKF_ASSERT_IMP(a_gain_le_one, clk, rst_n, done_reg, !(quotient[FRAC_BITS] && (|quotient[FRAC_BITS-1:0])))

endmodule

/* rtl/scalar_kalman_forward_filter.sv */
// ----------------------------------------------------------------------------
// Scalar Kalman forward filter - top level
// Forward pass of a scalar Kalman filter for an AR(1) level with jumps.
// ----------------------------------------------------------------------------
// Each accepted item carries one observed sample, the jump added to the level
// for that step and a restart flag, and produces one result item holding the
// predicted mean and variance and the filtered mean and variance, all in
// signed or unsigned fixed point with FRAC_BITS fraction bits and saturated
// to the DATA_WIDTH range. The block takes no new item until it has
// returned to idle after finishing the previous one: a single shared
// multiplier is stepped through five products by the sequencer, and the gain
// is formed by a restoring divider that produces one quotient bit per cycle,
// which accounts for most of the time. A finished item waits in the output
// register, so the next item may be accepted while the previous result has
// not yet been taken. Configuration registers are written through the plain
// write port; the user must write them only while the block is idle, since
// the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "scalar_kalman_forward_filter_defines.svh"

module scalar_kalman_forward_filter import skf_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    skf_in_if.sink                in_item,
    skf_out_if.source             out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_WIDTH-1:0] cfg_data
);

    localparam int DW   = DATA_WIDTH;
    // Multiplier operand widths: the A side takes the decay factor, its square
    // or the gain; the B side takes the mean, the decay factor, a variance or the innovation.
    localparam int MA_W = 2 * COEF_BITS + 1;
    localparam int MB_W = DW + 2;
    localparam int PW   = MA_W + MB_W;
    localparam int AW   = DW + 2;
    localparam int FW   = DW + 3;

    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-2:0]        VMAX = {(DW-1){1'b1}};

    // Configuration registers.
    logic [COEF_BITS-1:0]    ar_coef_reg;
    logic [DW-2:0]           process_var_reg;
    logic [DW-2:0]           obs_var_reg;
    logic signed [DW-1:0]    baseline_reg;
    logic [DW-2:0]           initial_var_reg;

    // Filter state.
    logic signed [DW-1:0]    m_reg;
    logic [DW-2:0]           v_reg;

    // Sequencer and working registers.
    skf_state_t              state_reg;
    skf_state_t              state_next;
    logic signed [DW-1:0]    y_reg;
    logic signed [DW-1:0]    jump_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [DW-1:0]    a_reg;
    logic [DW-2:0]           r_reg;
    logic signed [MB_W-1:0]  innov_reg;
    logic [FRAC_BITS:0]      gain_reg;
    logic signed [DW-1:0]    fm_reg;

    // Output register.
    logic                    out_valid_reg;
    logic signed [DW-1:0]    out_pm_reg;
    logic [DW-2:0]           out_pv_reg;
    logic signed [DW-1:0]    out_fm_reg;
    logic [DW-2:0]           out_fv_reg;

    // Sequencer outputs.
    logic                    in_take;
    logic                    mul_en;
    logic                    load_a;
    logic                    load_r;
    logic                    div_start;
    logic                    load_gain;
    logic                    load_fm;
    logic                    finish;
    logic                    out_free;

    // Datapath signals.
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [AW-1:0]    a_wide;
    logic signed [DW-1:0]    a_sat;
    logic [DW-1:0]           r_wide;
    logic [DW-2:0]           r_sat;
    logic signed [DW+1:0]    corr;
    logic signed [FW-1:0]    fm_wide;
    logic signed [DW-1:0]    fm_sat;
    logic [DW-1:0]           fv_wide;
    logic [DW-2:0]           fv_sat;
    logic                    div_done;
    logic [FRAC_BITS:0]      div_quo;

    // ------------------------------------------------------------------
    // Configuration port. Writes to an index beyond the list are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ar_coef_reg     <= AR_COEF_RST[COEF_BITS-1:0];
            process_var_reg <= VAR_ONE_RST[DW-2:0];
            obs_var_reg     <= VAR_ONE_RST[DW-2:0];
            baseline_reg    <= '0;
            initial_var_reg <= VAR_ONE_RST[DW-2:0];
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AR_COEF:     ar_coef_reg     <= cfg_data[COEF_BITS-1:0];
                REG_PROCESS_VAR: process_var_reg <= cfg_data[DW-2:0];
                REG_OBS_VAR:     obs_var_reg     <= cfg_data[DW-2:0];
                REG_BASELINE:    baseline_reg    <= $signed(cfg_data);
                REG_INITIAL_VAR: initial_var_reg <= cfg_data[DW-2:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || out_item.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_item.valid) state_next = ST_MUL_A;
            ST_MUL_A:    state_next = ST_MUL_GG;
            ST_MUL_GG:   state_next = ST_MUL_V;
            ST_MUL_V:    state_next = ST_SUM_R;
            ST_SUM_R:    state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (div_done) state_next = ST_MUL_FM;
            ST_MUL_FM:   state_next = ST_SUM_FM;
            ST_SUM_FM:   state_next = ST_SUM_FV;
            ST_SUM_FV:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: control outputs and multiplier operand selection.
    // ------------------------------------------------------------------
    always_comb
    begin
        in_take   = 1'b0;
        mul_en    = 1'b0;
        load_a    = 1'b0;
        load_r    = 1'b0;
        div_start = 1'b0;
        load_gain = 1'b0;
        load_fm   = 1'b0;
        finish    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_take = 1'b1;
            end
            ST_MUL_A:
            begin
                // g * m
                mul_en = 1'b1;
                mul_a  = MA_W'(ar_coef_reg);
                mul_b  = MB_W'(m_reg);
            end
            ST_MUL_GG:
            begin
                // g * g, while the predicted mean is taken from g * m.
                mul_en = 1'b1;
                load_a = 1'b1;
                mul_a  = MA_W'(ar_coef_reg);
                mul_b  = MB_W'(ar_coef_reg);
            end
            ST_MUL_V:
            begin
                // g^2 * v; the square sits in the low bits of the product.
                mul_en = 1'b1;
                mul_a  = $signed(prod_reg[MA_W-1:0]);
                mul_b  = MB_W'(v_reg);
            end
            ST_SUM_R:
            begin
                load_r = 1'b1;
            end
            ST_DIV_GO:
            begin
                div_start = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                load_gain = div_done;
            end
            ST_MUL_FM:
            begin
                // K * innovation
                mul_en = 1'b1;
                mul_a  = MA_W'(gain_reg);
                mul_b  = innov_reg;
            end
            ST_SUM_FM:
            begin
                // obs_var * K, while the filtered mean is formed.
                mul_en  = 1'b1;
                load_fm = 1'b1;
                mul_a   = MA_W'(gain_reg);
                mul_b   = MB_W'(obs_var_reg);
            end
            ST_SUM_FV:
            begin
                finish = out_free;
            end
            default:
            begin
                in_take = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_item.ready = in_take;

    // ------------------------------------------------------------------
    // Arithmetic around the shared multiplier.
    // ------------------------------------------------------------------
    // Predicted mean: floor(g * m / 2^16) + jump, saturated.
    assign a_wide = $signed(prod_reg[COEF_BITS +: AW]) + AW'(jump_reg);
    always_comb
    begin
        if ((|a_wide[AW-1:DW-1]) && !(&a_wide[AW-1:DW-1]))
        begin
            a_sat = a_wide[AW-1] ? SMIN : SMAX;
        end
        else
        begin
            a_sat = a_wide[DW-1:0];
        end
    end

    // Predicted variance: floor(g^2 * v / 2^32) + process_var, saturated.
    assign r_wide = DW'(prod_reg[2*COEF_BITS +: DW-1]) + DW'(process_var_reg);
    assign r_sat  = r_wide[DW-1] ? VMAX : r_wide[DW-2:0];

    // Filtered mean: a + floor(K * innovation / 2^FRAC_BITS), saturated.
    assign corr    = $signed(prod_reg[FRAC_BITS +: DW+2]);
    assign fm_wide = FW'(corr) + FW'(a_reg);
    always_comb
    begin
        if ((|fm_wide[FW-1:DW-1]) && !(&fm_wide[FW-1:DW-1]))
        begin
            fm_sat = fm_wide[FW-1] ? SMIN : SMAX;
        end
        else
        begin
            fm_sat = fm_wide[DW-1:0];
        end
    end

    // Filtered variance: floor(obs_var * K / 2^FRAC_BITS), saturated.
    assign fv_wide = prod_reg[FRAC_BITS +: DW];
    assign fv_sat  = fv_wide[DW-1] ? VMAX : fv_wide[DW-2:0];

    skf_div #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (r_reg),
        .den      (DW'(r_reg) + DW'(obs_var_reg)),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Working registers carry payload only and need no reset.
    always_ff @(posedge clk)
    begin
        if (in_take && in_item.valid)
        begin
            y_reg    <= in_item.sample;
            jump_reg <= in_item.jump;
        end
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (load_a)
        begin
            a_reg <= a_sat;
        end
        if (load_r)
        begin
            r_reg     <= r_sat;
            innov_reg <= MB_W'(y_reg) - MB_W'(baseline_reg) - MB_W'(a_reg);
        end
        if (load_gain)
        begin
            gain_reg <= div_quo;
        end
        if (load_fm)
        begin
            fm_reg <= fm_sat;
        end
        if (finish)
        begin
            out_pm_reg <= a_reg;
            out_pv_reg <= r_reg;
            out_fm_reg <= fm_reg;
            out_fv_reg <= fv_sat;
        end
    end

    // Filter state: a restart clears it before the step begins.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= '0;
            v_reg <= VAR_ONE_RST[DW-2:0];
        end
        else if (in_take && in_item.valid && in_item.restart)
        begin
            m_reg <= '0;
            v_reg <= initial_var_reg;
        end
        else if (finish)
        begin
            m_reg <= fm_reg;
            v_reg <= fv_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_item.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_item.valid          = out_valid_reg;
    assign out_item.predicted_mean = out_pm_reg;
    assign out_item.predicted_var  = out_pv_reg;
    assign out_item.filtered_mean  = out_fm_reg;
    assign out_item.filtered_var   = out_fv_reg;

    `SKF_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_take && in_item.valid, !in_item.ready)
    `SKF_ASSERT_IMP(a_div_done_in_wait, clk, rst_n, div_done, state_reg == ST_DIV_WAIT)
    `SKF_ASSERT_NXT(a_restart_clears, clk, rst_n, in_take && in_item.valid && in_item.restart, m_reg == '0)
    `SKF_ASSERT_NXT(a_finish_shows, clk, rst_n, finish, out_valid_reg && state_reg == ST_IDLE)

endmodule

/* bench/tb_scalar_kalman_forward_filter.sv */
// ----------------------------------------------------------------------------
// Scalar Kalman forward filter - self-checking testbench
// Drives observation items through the filter under several register
// settings, predicts every result item in a fixed-point model of its own and
// compares each field, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_forward_filter import skf_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DATA_WIDTH     = DATA_WIDTH_DEF;
    localparam int          FRAC_BITS      = FRAC_BITS_DEF;
    localparam int unsigned ITEMS_PER_SET  = 118;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES    = 600;
    localparam int unsigned HOLD_AT_FIRST  = 150;
    localparam int unsigned HOLD_AT_SECOND = 700;
    localparam int unsigned DRAIN_CYCLES   = 64;
    localparam int unsigned MAX_PRINTED    = 40;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // Ways in which the result side takes items.
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_TRICKLE
    } sink_mode_t;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] predicted_mean;
        logic        [DATA_WIDTH-2:0] predicted_var;
        logic signed [DATA_WIDTH-1:0] filtered_mean;
        logic        [DATA_WIDTH-2:0] filtered_var;
    } kalman_estimate_t;

    // ------------------------------------------------------------------------
    // Filter scoreboard: keeps its own copy of the registers and of the level
    // state, predicts one estimate per accepted observation and compares the
    // estimates that come out of the block in order.
    // ------------------------------------------------------------------------
    class filter_scoreboard;
        localparam longint MEAN_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
        localparam longint MEAN_MIN = -MEAN_MAX - 1;

        longint unsigned decay;
        longint unsigned proc_noise;
        longint unsigned obs_noise;
        longint          offset;
        longint unsigned start_var;

        longint          level_mean;
        longint unsigned level_var;

        kalman_estimate_t pending_estimates[$];

        int unsigned errors;
        int unsigned results_checked;
        int unsigned restarts;
        int unsigned zero_gain_steps;
        int unsigned clamped_values;

        function new();
            decay      = AR_COEF_RST;
            proc_noise = VAR_ONE_RST;
            obs_noise  = VAR_ONE_RST;
            offset     = 0;
            start_var  = VAR_ONE_RST;
            level_mean = 0;
            level_var  = VAR_ONE_RST;
        endfunction

        function int unsigned pending();
            return pending_estimates.size();
        endfunction

        function void set_register(cfg_idx_t idx, logic [31:0] data);
            case (idx)
                REG_AR_COEF:     decay      = data[COEF_BITS-1:0];
                REG_PROCESS_VAR: proc_noise = data[30:0];
                REG_OBS_VAR:     obs_noise  = data[30:0];
                REG_BASELINE:    offset     = longint'(signed'(data));
                REG_INITIAL_VAR: start_var  = data[30:0];
                default:         ;
            endcase
        endfunction

        function longint clamp_mean(longint x);
            if (x > MEAN_MAX)
            begin
                clamped_values++;
                return MEAN_MAX;
            end
            if (x < MEAN_MIN)
            begin
                clamped_values++;
                return MEAN_MIN;
            end
            return x;
        endfunction

        function longint unsigned clamp_var(longint unsigned x);
            if (x > longint'(MEAN_MAX))
            begin
                clamped_values++;
                return MEAN_MAX;
            end
            return x;
        endfunction

        // One filter step: predict, form the gain, correct and keep the
        // corrected pair as the level for the next observation.
        function void note_observation(logic [31:0] sample, logic [31:0] jump, logic restart);
            longint           prior_mean;
            longint           innovation;
            longint           post_mean;
            longint unsigned  prior_var;
            longint unsigned  denom;
            longint unsigned  gain;
            longint unsigned  post_var;
            kalman_estimate_t est;

            if (restart)
            begin
                restarts++;
                level_mean = 0;
                level_var  = start_var;
            end

            prior_mean = clamp_mean(((longint'(decay) * level_mean) >>> COEF_BITS)
                                    + longint'(signed'(jump)));
            prior_var  = clamp_var(((decay * decay * level_var) >> (2 * COEF_BITS))
                                   + proc_noise);

            denom = prior_var + obs_noise;
            if (denom == 0)
            begin
                zero_gain_steps++;
                gain = 0;
            end
            else
                gain = (prior_var << FRAC_BITS) / denom;

            // The innovation is kept at full width; only the sum saturates.
            innovation = longint'(signed'(sample)) - offset - prior_mean;
            post_mean  = clamp_mean(prior_mean + ((longint'(gain) * innovation) >>> FRAC_BITS));
            post_var   = clamp_var((obs_noise * gain) >> FRAC_BITS);

            level_mean = post_mean;
            level_var  = post_var;

            est.predicted_mean = prior_mean[DATA_WIDTH-1:0];
            est.predicted_var  = prior_var[DATA_WIDTH-2:0];
            est.filtered_mean  = post_mean[DATA_WIDTH-1:0];
            est.filtered_var   = post_var[DATA_WIDTH-2:0];
            pending_estimates.push_back(est);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_estimate(kalman_estimate_t got);
            kalman_estimate_t want;
            results_checked++;
            if (pending_estimates.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with no estimate waiting",
                                          results_checked));
                return;
            end
            want = pending_estimates.pop_front();
            if (got.predicted_mean !== want.predicted_mean)
                report_mismatch($sformatf("result %0d predicted_mean got %0d, expected %0d",
                                          results_checked, got.predicted_mean,
                                          want.predicted_mean));
            if (got.predicted_var !== want.predicted_var)
                report_mismatch($sformatf("result %0d predicted_var got %0d, expected %0d",
                                          results_checked, got.predicted_var,
                                          want.predicted_var));
            if (got.filtered_mean !== want.filtered_mean)
                report_mismatch($sformatf("result %0d filtered_mean got %0d, expected %0d",
                                          results_checked, got.filtered_mean,
                                          want.filtered_mean));
            if (got.filtered_var !== want.filtered_var)
                report_mismatch($sformatf("result %0d filtered_var got %0d, expected %0d",
                                          results_checked, got.filtered_var,
                                          want.filtered_var));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block itself.
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [DATA_WIDTH-1:0] cfg_data;

    skf_in_if  #(.DATA_WIDTH(DATA_WIDTH)) in_ch ();
    skf_out_if #(.DATA_WIDTH(DATA_WIDTH)) out_ch ();

    filter_scoreboard sb = new();

    int unsigned items_sent;
    int unsigned settings_run;

    scalar_kalman_forward_filter #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_ch),
        .out_item  (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Everything is driven with nonblocking assignments just
    // after a rising edge, and handshakes are judged on the values that were
    // present at the edge itself.
    // ------------------------------------------------------------------------

    // A Q16.16 value for a sample or a jump. Part of the values sit in a realistic
    // band of +/-32.0 so that the level tracks something sensible; the rest
    // are zeros, whole-word random values and the corners of the range.
    function automatic logic [31:0] pick_q16(int unsigned zero_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < zero_pct)
            return '0;
        if (roll < zero_pct + 8)
        begin
            case ($urandom_range(4))
                0:       return Q_MAX;
                1:       return Q_MIN;
                2:       return ALL_ONES;
                3:       return 32'h0000_0001;
                default: return Q_ONE;
            endcase
        end
        if (roll < zero_pct + 40)
            return $urandom;
        return $urandom_range(32'h0040_0000) - 32'h0020_0000;
    endfunction

    // Offers one observation item and returns once it has been accepted.
    // The valid flag is left high so that a following item in the same burst
    // goes out without a bubble.
    task automatic send_item(logic [31:0] sample, logic [31:0] jump, logic restart);
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= sample;
        in_ch.jump    <= jump;
        in_ch.restart <= restart;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_observation(sample, jump, restart);
        items_sent++;
    endtask

    // Writes one register; the enable stays high across a run of writes.
    task automatic write_register(cfg_idx_t idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(idx, data);
    endtask

    // Waits until the block has handed over every estimate it owes, which
    // means it is idle, and then loads a complete register setting.
    task automatic apply_setting(logic [31:0] decay, logic [31:0] proc_noise,
                                 logic [31:0] obs_noise, logic [31:0] offset,
                                 logic [31:0] start_var);
        while (sb.pending() != 0)
            @(posedge clk);
        write_register(REG_AR_COEF, decay);
        write_register(REG_PROCESS_VAR, proc_noise);
        write_register(REG_OBS_VAR, obs_noise);
        write_register(REG_BASELINE, offset);
        write_register(REG_INITIAL_VAR, start_var);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_run++;
    endtask

    // Corner items sent back to back: both ends of the sample and jump
    // ranges, opposing extremes that drive the innovation past the word
    // width, small values either side of zero, and restarts in between.
    task automatic run_directed();
        send_item('0, '0, 1'b1);
        send_item(Q_MAX, '0, 1'b0);
        send_item(Q_MAX, Q_MAX, 1'b0);
        send_item(Q_MIN, Q_MIN, 1'b0);
        send_item(Q_MIN, Q_MAX, 1'b1);
        send_item(Q_MAX, Q_MIN, 1'b0);
        send_item(ALL_ONES, 32'h0000_0001, 1'b0);
        send_item(32'h0000_0001, ALL_ONES, 1'b0);
        send_item(Q_ONE, Q_ONE, 1'b1);
        send_item(Q_MIN, '0, 1'b0);
        send_item('0, '0, 1'b0);
        send_item(Q_MAX, '0, 1'b1);
    endtask

    // Random observations in bursts of random length. About a third of the
    // bursts follow the previous one without a gap, so there are stretches
    // where the sender never idles.
    task automatic run_random(int unsigned count);
        int unsigned left_in_burst;
        int unsigned gap;
        left_in_burst = 0;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (left_in_burst == 0)
            begin
                left_in_burst = $urandom_range(1, 16);
                gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0)
                begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            send_item(pick_q16(30), pick_q16(60), $urandom_range(11) == 0);
            left_in_burst--;
        end
        in_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side. The ready pattern switches between always taking items,
    // taking them at random and taking one now and then. Twice in the run it
    // holds off for a long stretch while the sender keeps offering, so the
    // output register fills, the block finishes the next item and then has to
    // refuse further input.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        sink_mode_t       mode;
        int unsigned      mode_left;
        int unsigned      hold_left;
        int unsigned      results_taken;
        kalman_estimate_t got;

        mode          = SINK_OPEN;
        mode_left     = 0;
        hold_left     = 0;
        results_taken = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got.predicted_mean = out_ch.predicted_mean;
                got.predicted_var  = out_ch.predicted_var;
                got.filtered_mean  = out_ch.filtered_mean;
                got.filtered_var   = out_ch.filtered_var;
                sb.check_estimate(got);
                results_taken++;
                if (results_taken == HOLD_AT_FIRST || results_taken == HOLD_AT_SECOND)
                    hold_left = HOLD_CYCLES;
            end

            if (mode_left == 0)
            begin
                mode      = sink_mode_t'($urandom_range(2));
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left--;

            if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    SINK_OPEN:    out_ch.ready <= 1'b1;
                    SINK_RANDOM:  out_ch.ready <= $urandom_range(1);
                    SINK_TRICKLE: out_ch.ready <= ($urandom_range(7) == 0);
                    default:      out_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a long run of cycles with no item moving on either channel
    // means the block has hung.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] TIMEOUT: no item moved for %0d cycles, %0d estimates owed",
                         $realtime, quiet, sb.pending());
                $display("tb_scalar_kalman_forward_filter: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        items_sent   = 0;
        settings_run = 0;

        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.sample  <= '0;
        in_ch.jump    <= '0;
        in_ch.restart <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_AR_COEF;
        cfg_data      <= '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The register values that reset leaves behind.
        settings_run++;
        run_directed();
        run_random(ITEMS_PER_SET);

        // Everything at zero: the prior variance is always zero and so is the
        // denominator, which leaves the gain at zero on every step.
        apply_setting('0, '0, '0, '0, '0);
        run_directed();
        run_random(ITEMS_PER_SET);

        // Every register at the top of its range, written with all ones so
        // that the bits above each register's width must be dropped; the
        // baseline sits at its most negative value.
        apply_setting(ALL_ONES, ALL_ONES, ALL_ONES, Q_MIN, ALL_ONES);
        run_directed();
        run_random(ITEMS_PER_SET);

        // No observation noise, so the gain is exactly one and the filtered
        // mean follows the baseline-removed sample. The writes to the unused
        // indexes afterwards must change nothing.
        apply_setting(32'h0000_8000, 32'h0000_1000, '0, Q_MAX, Q_ONE);
        for (int k = int'(REG_INITIAL_VAR) + 1; k < (1 << CFG_IDX_W); k++)
            write_register(cfg_idx_t'(k), ALL_ONES);
        cfg_we <= 1'b0;
        run_directed();
        run_random(ITEMS_PER_SET);

        // The smallest non-zero value everywhere, baseline just below zero.
        apply_setting(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_0000,
                      32'h0000_0001);
        run_directed();
        run_random(ITEMS_PER_SET);

        // Whole-word random settings.
        apply_setting($urandom, $urandom, $urandom, $urandom, $urandom);
        run_directed();
        run_random(ITEMS_PER_SET);

        // Random settings in a realistic band.
        apply_setting($urandom_range(32'h0000_FFFF), $urandom_range(32'h0010_0000),
                      $urandom_range(32'h0010_0000), pick_q16(20),
                      $urandom_range(32'h0010_0000));
        run_directed();
        run_random(ITEMS_PER_SET);

        // Back to the reset values, written explicitly this time.
        apply_setting(AR_COEF_RST[31:0], VAR_ONE_RST[31:0], VAR_ONE_RST[31:0], '0,
                      VAR_ONE_RST[31:0]);
        run_directed();
        run_random(ITEMS_PER_SET);

        // Collect what is still owed, then give the block time to show any
        // result that it should not produce.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d observations under %0d register settings with %0d restarts,",
                 items_sent, settings_run, sb.restarts);
        $display("%0d zero-gain steps and %0d saturated values; %0d estimates checked.",
                 sb.zero_gain_steps, sb.clamped_values, sb.results_checked);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_scalar_kalman_forward_filter: done, clean");
        else
            $display("tb_scalar_kalman_forward_filter: done, errors");
        $finish;
    end

endmodule
